@@ hw/rtl/kmsr_pkg.sv @@
// Shared types, key tables and constants for the key matrix scanner.
`default_nettype none
package kmsr_pkg;

  localparam int unsigned NumCols  = 8;
  localparam int unsigned NumRows  = 7;
  localparam int unsigned ColW     = 3;
  localparam int unsigned RowW     = 3;
  localparam int unsigned HeldW    = 6;
  localparam int unsigned DelayW   = 8;

  // Row bit that carries the modifier keys in columns 3, 4 and 7.
  localparam logic [RowW-1:0] ModRow   = 3'd6;
  localparam logic [ColW-1:0] CtrlCol  = 3'd4;
  localparam logic [ColW-1:0] ShiftCol = 3'd7;

  localparam logic [7:0] KeyOne    = 8'h31;
  localparam logic [7:0] KeyTwo    = 8'h32;
  localparam logic [7:0] CtrlMask  = 8'h1F;
  localparam logic [7:0] CtrlLow   = 8'd32;
  localparam logic [7:0] CtrlHigh  = 8'd127;

  localparam logic [DelayW-1:0] FirstDelayRst = 8'd25;
  localparam logic [DelayW-1:0] NextDelayRst  = 8'd5;

  // Configuration register indexes.
  localparam logic [1:0] CfgFirstDelay = 2'd0;
  localparam logic [1:0] CfgNextDelay  = 2'd1;

  typedef logic [0:NumCols-1][0:NumRows-1][7:0] key_tab_t;

  localparam key_tab_t PlainTab = '{
    '{8'h40, 8'h68, 8'h70, 8'h78, 8'h30, 8'h38, 8'h0D},
    '{8'h61, 8'h69, 8'h71, 8'h79, 8'h31, 8'h39, 8'h00},
    '{8'h62, 8'h6A, 8'h72, 8'h7A, 8'h32, 8'h3A, 8'h1B},
    '{8'h63, 8'h6B, 8'h73, 8'h5E, 8'h33, 8'h3B, 8'h00},
    '{8'h64, 8'h6C, 8'h74, 8'h7C, 8'h34, 8'h2C, 8'h00},
    '{8'h65, 8'h6D, 8'h75, 8'h08, 8'h35, 8'h2D, 8'h7E},
    '{8'h66, 8'h6E, 8'h76, 8'h09, 8'h36, 8'h2E, 8'h60},
    '{8'h67, 8'h6F, 8'h77, 8'h20, 8'h37, 8'h2F, 8'h00}
  };

  localparam key_tab_t ShiftTab = '{
    '{8'h5C, 8'h48, 8'h50, 8'h58, 8'h5F, 8'h28, 8'h0D},
    '{8'h41, 8'h49, 8'h51, 8'h59, 8'h21, 8'h29, 8'h00},
    '{8'h42, 8'h4A, 8'h52, 8'h5A, 8'h22, 8'h2A, 8'h03},
    '{8'h43, 8'h4B, 8'h53, 8'h5B, 8'h23, 8'h2B, 8'h00},
    '{8'h44, 8'h4C, 8'h54, 8'h5D, 8'h24, 8'h3C, 8'h00},
    '{8'h45, 8'h4D, 8'h55, 8'h7B, 8'h25, 8'h3D, 8'h7C},
    '{8'h46, 8'h4E, 8'h56, 8'h7D, 8'h26, 8'h3E, 8'h00},
    '{8'h47, 8'h4F, 8'h57, 8'h20, 8'h27, 8'h3F, 8'h00}
  };

  typedef struct packed {
    logic [7:0] column0_rows;
    logic [7:0] column1_rows;
    logic [7:0] column2_rows;
    logic [7:0] column3_rows;
    logic [7:0] column4_rows;
    logic [7:0] column5_rows;
    logic [7:0] column6_rows;
    logic [7:0] column7_rows;
  } scan_in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic       console_index;
    logic       console_switched;
  } scan_out_t;

  // Result of comparing one column with its stored map entry.
  typedef struct packed {
    logic [NumRows-1:0] now;
    logic [RowW-1:0]    presses;
    logic [RowW-1:0]    releases;
    logic               hit;
    logic [RowW-1:0]    last_row;
  } col_res_t;

  typedef struct packed {
    logic       is_switch;
    logic       console;
    logic [7:0] code;
  } dec_res_t;

  function automatic logic [NumRows-1:0] mod_mask(input logic [ColW-1:0] col);
    logic [NumRows-1:0] m;
    m = '0;
    if (col == 3'd3 || col == CtrlCol || col == ShiftCol) begin
      m[ModRow] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/kmsr_col_unit.sv @@
// Compares one column of row sense bits with the stored key map.
`default_nettype none
module kmsr_col_unit (
  input  wire logic [7:0]                     rows_i,
  input  wire logic [kmsr_pkg::NumRows-1:0]   old_i,
  input  wire logic [kmsr_pkg::ColW-1:0]      col_i,
  output kmsr_pkg::col_res_t                  res_o
);
  import kmsr_pkg::*;

  logic [NumRows-1:0] now;
  logic [NumRows-1:0] change;
  logic [RowW-1:0]    n_press;
  logic [RowW-1:0]    n_rel;
  logic               hit;
  logic [RowW-1:0]    last;

  // Rows are active low; later rows overwrite earlier presses.
  always_comb begin
    now    = ~rows_i[NumRows-1:0];
    change = (now ^ old_i) & ~mod_mask(col_i);
    n_press = '0;
    n_rel   = '0;
    hit     = 1'b0;
    last    = '0;
    for (int n = 0; n < NumRows; n++) begin
      if (change[n]) begin
        if (old_i[n]) begin
          n_rel = n_rel + 3'd1;
        end else begin
          n_press = n_press + 3'd1;
          hit     = 1'b1;
          last    = RowW'(n);
        end
      end
    end
    res_o.now      = now;
    res_o.presses  = n_press;
    res_o.releases = n_rel;
    res_o.hit      = hit;
    res_o.last_row = last;
  end

endmodule
`default_nettype wire

@@ hw/rtl/kmsr_decode.sv @@
// Maps the current key to a character, with shift, control masking and console keys.
`default_nettype none
module kmsr_decode (
  input  wire logic                       shift_i,
  input  wire logic                       ctrl_i,
  input  wire logic [kmsr_pkg::ColW-1:0]  col_i,
  input  wire logic [kmsr_pkg::RowW-1:0]  row_i,
  output kmsr_pkg::dec_res_t              res_o
);
  import kmsr_pkg::*;

  logic [RowW-1:0] row;
  logic [7:0]      raw;

  always_comb begin
    row = (row_i > ModRow) ? ModRow : row_i;
    raw = shift_i ? ShiftTab[col_i][row] : PlainTab[col_i][row];
    res_o.is_switch = 1'b0;
    res_o.console   = (raw == KeyTwo);
    res_o.code      = raw;
    if (ctrl_i) begin
      if (raw == KeyOne || raw == KeyTwo) begin
        res_o.is_switch = 1'b1;
      end else if (raw > CtrlLow && raw < CtrlHigh) begin
        res_o.code = raw & CtrlMask;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/key_matrix_scan_repeat_decode_top.sv @@
// Top level of the key matrix scanner with autorepeat and console switching.
//
//   port group   dir  handshake            word
//   in_*         in   in_valid_i/in_stall_o  scan_in_t, eight row sense bytes
//   out_*        out  out_valid_o/out_stall_i scan_out_t, one result per scan
//   cfg_*        in   cfg_valid_i/cfg_ready_o index and 8-bit delay value
//
// Each scan word is captured, then the shared column unit compares one
// column per cycle across the eight columns, and a final step runs the
// repeat timer and decode. Reset clears the key map, counters, timer and
// console and loads the default delays. A stalled result sits in the output
// register; the next word can be captured and scanned meanwhile, and the
// final step waits until the output register is free.
`default_nettype none
module key_matrix_scan_repeat_decode_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire kmsr_pkg::scan_in_t in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      kmsr_pkg::scan_out_t out_data_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);
  import kmsr_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [ColW-1:0]     col_q, col_d;
  scan_in_t            in_q;
  logic [NumRows-1:0]  map_q [NumCols];
  logic [HeldW-1:0]    held_q, held_d;
  logic [ColW-1:0]     cur_col_q, cur_col_d;
  logic [RowW-1:0]     cur_row_q, cur_row_d;
  logic                fresh_q, fresh_d;
  logic [DelayW-1:0]   timer_q, timer_d;
  logic                console_q, console_d;
  logic [DelayW-1:0]   first_q, next_q;
  logic                out_valid_q;
  scan_out_t           out_q, out_d;
  logic                out_load;

  logic [7:0]          col_rows;
  col_res_t            col_res;
  dec_res_t            dec_res;
  logic [DelayW-1:0]   timer_dec;
  logic                do_decode;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (col_q)
      3'd0:    col_rows = in_q.column0_rows;
      3'd1:    col_rows = in_q.column1_rows;
      3'd2:    col_rows = in_q.column2_rows;
      3'd3:    col_rows = in_q.column3_rows;
      3'd4:    col_rows = in_q.column4_rows;
      3'd5:    col_rows = in_q.column5_rows;
      3'd6:    col_rows = in_q.column6_rows;
      default: col_rows = in_q.column7_rows;
    endcase
  end

  kmsr_col_unit u_col (
    .rows_i (col_rows),
    .old_i  (map_q[col_q]),
    .col_i  (col_q),
    .res_o  (col_res)
  );

  kmsr_decode u_dec (
    .shift_i (map_q[ShiftCol][ModRow]),
    .ctrl_i  (map_q[CtrlCol][ModRow]),
    .col_i   (cur_col_q),
    .row_i   (cur_row_q),
    .res_o   (dec_res)
  );

  assign timer_dec = timer_q - 8'd1;

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    held_d    = held_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    fresh_d   = fresh_q;
    timer_d   = timer_q;
    console_d = console_q;
    out_load  = 1'b0;
    do_decode = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StScan;
          col_d   = '0;
          fresh_d = 1'b0;
        end
      end
      StScan: begin
        // Held count is modular, so adding a column's net change at once is exact.
        held_d = held_q + HeldW'(col_res.presses) - HeldW'(col_res.releases);
        if (col_res.hit) begin
          fresh_d   = 1'b1;
          cur_col_d = col_q;
          cur_row_d = col_res.last_row;
        end
        col_d = col_q + 3'd1;
        if (col_q == ColW'(NumCols - 1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
          if (held_q != '0 && held_q < 6'd3) begin
            if (fresh_q) begin
              do_decode = 1'b1;
              timer_d   = first_q;
            end else if (timer_dec == '0) begin
              do_decode = 1'b1;
              timer_d   = next_q;
            end else begin
              timer_d = timer_dec;
            end
          end
          out_d.char_valid       = 1'b0;
          out_d.char_code        = '0;
          out_d.console_switched = 1'b0;
          if (do_decode) begin
            if (dec_res.is_switch) begin
              console_d              = dec_res.console;
              out_d.console_switched = 1'b1;
            end else begin
              out_d.char_valid = 1'b1;
              out_d.char_code  = dec_res.code;
            end
          end
          out_d.console_index = console_d;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      held_q      <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      fresh_q     <= 1'b0;
      timer_q     <= '0;
      console_q   <= 1'b0;
      first_q     <= FirstDelayRst;
      next_q      <= NextDelayRst;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCols; i++) begin
        map_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      held_q    <= held_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      fresh_q   <= fresh_d;
      timer_q   <= timer_d;
      console_q <= console_d;
      if (state_q == StScan) begin
        map_q[col_q] <= col_res.now;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgFirstDelay: first_q <= cfg_data_i;
          CfgNextDelay:  next_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

endmodule
`default_nettype wire
